/* rtl/core/pawc_pkg.sv */
// Shared types and constants for the polygon area, winding and convexity block.
// No dependencies; the files in rtl/core that use it refer to it by scoped names.
package pawc_pkg;

  // Width of the doubled-area accumulator and result
  localparam int AREA_BITS = 48;
  localparam logic signed [AREA_BITS-1:0] AREA_MAX = {1'b0, {(AREA_BITS-1){1'b1}}};
  localparam logic signed [AREA_BITS-1:0] AREA_MIN = {1'b1, {(AREA_BITS-1){1'b0}}};

  // Vertex counter, saturating once four vertices have been seen
  localparam int COUNT_BITS = 3;
  localparam logic [COUNT_BITS-1:0] COUNT_SECOND = 3'd1;
  localparam logic [COUNT_BITS-1:0] COUNT_TURN   = 3'd2;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX    = 3'd4;

  // Slots of the coordinate bundle handed from front to back
  localparam int CRD_CX    = 0;
  localparam int CRD_CY    = 1;
  localparam int CRD_PX    = 2;
  localparam int CRD_PY    = 3;
  localparam int CRD_OX    = 4;
  localparam int CRD_OY    = 5;
  localparam int CRD_FX    = 6;
  localparam int CRD_FY    = 7;
  localparam int CRD_SX    = 8;
  localparam int CRD_SY    = 9;
  localparam int CRD_COUNT = 10;

  // What the back end must do with one vertex word
  typedef struct packed {
    logic acc;         // add prior x current to the shoelace sum
    logic turn;        // evaluate turn (older, prior, current)
    logic first_turn;  // that turn sets the winding reference
    logic last;        // polygon ends here, emit a result
    logic closing;     // last with at least three vertices: close the loop
  } step_cls_t;

endpackage

/* rtl/core/pawc_vertex_if.sv */
// Vertex input channel: valid/ready handshake carrying one polygon vertex.
// Depends on nothing.
interface pawc_vertex_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         last_vertex;

  modport source(output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink(input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

/* rtl/core/pawc_result_if.sv */
// Result output channel: valid/ready handshake carrying one polygon result.
// Depends on pawc_pkg for the area width.
interface pawc_result_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [pawc_pkg::AREA_BITS-1:0] doubled_area;
  logic                                   counterclockwise;
  logic                                   convex;
  logic                                   area_saturated;

  modport source(output valid, doubled_area, counterclockwise, convex, area_saturated,
                 input ready);
  modport sink(input valid, doubled_area, counterclockwise, convex, area_saturated,
               output ready);
endinterface

/* rtl/core/polygon_area_winding_convexity.sv */
// Top level of the polygon area, winding and convexity block.
// Depends on pawc_pkg, pawc_vertex_if, pawc_result_if, pawc_front, pawc_queue, pawc_back.
//
//   channel   dir   word                                               handshake
//   vertex    in    vertex_x, vertex_y (signed), last_vertex           valid/ready
//   result    out   doubled_area (48b signed), counterclockwise,       valid/ready
//                   convex, area_saturated
//
// Takes one vertex per cycle while no result waits; the rate is set by the single
// accumulate stage that adds one shoelace term per cycle.
// Reset (rst, synchronous) empties the queue and pipeline and clears the running sums.
// A waiting result holds the back pipeline; the two-word queue keeps vertex.ready
// high until it fills.
module polygon_area_winding_convexity #(
  parameter int COORD_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  pawc_vertex_if.sink   vertex,
  pawc_result_if.source result
);

  localparam int ENTRY_BITS = $bits(pawc_pkg::step_cls_t) + pawc_pkg::CRD_COUNT * COORD_BITS;

  logic                  push_valid, push_ready;
  logic [ENTRY_BITS-1:0] push_data;
  logic                  pop_valid, pop_ready;
  logic [ENTRY_BITS-1:0] pop_data;

  pawc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .vertex     (vertex),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  pawc_queue #(.WIDTH(ENTRY_BITS)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  pawc_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule

/* rtl/core/pawc_front.sv */
// Front end: accepts vertices, keeps the vertex history and classifies each word.
// Depends on pawc_pkg and pawc_vertex_if; feeds pawc_queue.
module pawc_front #(
  parameter int COORD_BITS = 16,
  localparam int ENTRY_BITS = $bits(pawc_pkg::step_cls_t) + pawc_pkg::CRD_COUNT * COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  pawc_vertex_if.sink           vertex,
  output logic                  push_valid,
  input  logic                  push_ready,
  output logic [ENTRY_BITS-1:0] push_data
);

  localparam int CLS_BITS = $bits(pawc_pkg::step_cls_t);

  logic [COORD_BITS-1:0]            first_x, first_y, second_x, second_y;
  logic [COORD_BITS-1:0]            older_x, older_y, prior_x, prior_y;
  logic [pawc_pkg::COUNT_BITS-1:0]  seen_count;
  logic [pawc_pkg::COUNT_BITS-1:0]  seen_count_next;
  logic [COORD_BITS-1:0]            crd [pawc_pkg::CRD_COUNT];
  pawc_pkg::step_cls_t              cls;
  logic                             accept;

  // Pass the handshake straight to the queue
  assign vertex.ready = push_ready;
  assign push_valid   = vertex.valid;
  assign accept       = vertex.valid && push_ready;

  // Classify the word from the number of vertices seen so far
  always_comb begin
    cls.acc        = (seen_count != '0);
    cls.turn       = (seen_count inside {[pawc_pkg::COUNT_TURN:pawc_pkg::COUNT_MAX]});
    cls.first_turn = (seen_count == pawc_pkg::COUNT_TURN);
    cls.last       = vertex.last_vertex;
    cls.closing    = vertex.last_vertex && cls.turn;
  end

  // Gather the coordinates the back end needs
  always_comb begin
    crd[pawc_pkg::CRD_CX] = vertex.vertex_x;
    crd[pawc_pkg::CRD_CY] = vertex.vertex_y;
    crd[pawc_pkg::CRD_PX] = prior_x;
    crd[pawc_pkg::CRD_PY] = prior_y;
    crd[pawc_pkg::CRD_OX] = older_x;
    crd[pawc_pkg::CRD_OY] = older_y;
    crd[pawc_pkg::CRD_FX] = first_x;
    crd[pawc_pkg::CRD_FY] = first_y;
    crd[pawc_pkg::CRD_SX] = second_x;
    crd[pawc_pkg::CRD_SY] = second_y;
  end

  // Pack class on top, coordinates below in slot order
  always_comb begin
    push_data[ENTRY_BITS-1 -: CLS_BITS] = cls;
    for (int j = 0; j < pawc_pkg::CRD_COUNT; j++) begin
      push_data[(pawc_pkg::CRD_COUNT-1-j)*COORD_BITS +: COORD_BITS] = crd[j];
    end
  end

  // Advance the counter, saturating, and drop back to zero after the last vertex
  always_comb begin
    seen_count_next = seen_count;
    if (vertex.last_vertex) begin
      seen_count_next = '0;
    end else if (seen_count != pawc_pkg::COUNT_MAX) begin
      seen_count_next = seen_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= '0;
    end else if (accept) begin
      seen_count <= seen_count_next;
    end
  end

  // Shift the vertex history
  always_ff @(posedge clk) begin
    if (accept) begin
      if (seen_count == '0) begin
        first_x <= vertex.vertex_x;
        first_y <= vertex.vertex_y;
      end
      if (seen_count == pawc_pkg::COUNT_SECOND) begin
        second_x <= vertex.vertex_x;
        second_y <= vertex.vertex_y;
      end
      older_x <= prior_x;
      older_y <= prior_y;
      prior_x <= vertex.vertex_x;
      prior_y <= vertex.vertex_y;
    end
  end

endmodule

/* rtl/core/pawc_queue.sv */
// Short first-in first-out queue that decouples the front end from the back end.
// Generic payload width; no package dependency.
module pawc_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH     = 2;
  localparam int PTR_BITS  = $clog2(DEPTH);
  localparam int FILL_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]     mem [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [FILL_BITS-1:0] fill;
  logic                 do_push, do_pop;

  assign push_ready = (fill != FILL_BITS'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/pawc_back.sv */
// Back end: differences, products, cross terms, saturating accumulate and result.
// Depends on pawc_pkg and pawc_result_if; drains pawc_queue.
module pawc_back #(
  parameter int COORD_BITS = 16,
  localparam int ENTRY_BITS = $bits(pawc_pkg::step_cls_t) + pawc_pkg::CRD_COUNT * COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  logic [ENTRY_BITS-1:0] pop_data,
  pawc_result_if.source         result
);

  localparam int CLS_BITS = $bits(pawc_pkg::step_cls_t);
  localparam int AB       = pawc_pkg::AREA_BITS;
  localparam int DW       = COORD_BITS + 1;         // coordinate difference
  localparam int PW       = 2 * COORD_BITS;         // coordinate product
  localparam int QW       = 2 * DW;                 // difference product
  localparam int TERM     = PW + 1;                 // shoelace term
  localparam int TW       = QW + 1;                 // turn cross product
  localparam int SW       = ((AB > TERM) ? AB : TERM) + 1;
  localparam int NDIFF    = 12;
  localparam int NPROD    = 4;

  // Operand slots: turn t uses diffs 4t..4t+3 as (a*b) - (c*d)
  localparam int DIFF_A [NDIFF] = '{
    pawc_pkg::CRD_PX, pawc_pkg::CRD_CY, pawc_pkg::CRD_PY, pawc_pkg::CRD_CX,
    pawc_pkg::CRD_CX, pawc_pkg::CRD_FY, pawc_pkg::CRD_CY, pawc_pkg::CRD_FX,
    pawc_pkg::CRD_FX, pawc_pkg::CRD_SY, pawc_pkg::CRD_FY, pawc_pkg::CRD_SX};
  localparam int DIFF_B [NDIFF] = '{
    pawc_pkg::CRD_OX, pawc_pkg::CRD_OY, pawc_pkg::CRD_OY, pawc_pkg::CRD_OX,
    pawc_pkg::CRD_PX, pawc_pkg::CRD_PY, pawc_pkg::CRD_PY, pawc_pkg::CRD_PX,
    pawc_pkg::CRD_CX, pawc_pkg::CRD_CY, pawc_pkg::CRD_CY, pawc_pkg::CRD_CX};
  // Shoelace products: term 0 = p0 - p1 (prior x current), term 1 = p2 - p3 (closing)
  localparam int PROD_A [NPROD] = '{
    pawc_pkg::CRD_PX, pawc_pkg::CRD_PY, pawc_pkg::CRD_CX, pawc_pkg::CRD_CY};
  localparam int PROD_B [NPROD] = '{
    pawc_pkg::CRD_CY, pawc_pkg::CRD_CX, pawc_pkg::CRD_FY, pawc_pkg::CRD_FX};

  typedef struct packed {
    logic neg;
    logic pos;
  } turn_sign_t;

  typedef struct packed {
    logic nonneg;
    logic first_ccw;
    logic mismatch;
    logic clipped;
  } poly_flags_t;

  localparam poly_flags_t FLAGS_RESET = '{nonneg: 1'b1, first_ccw: 1'b1,
                                          mismatch: 1'b0, clipped: 1'b0};

  // Fold one turn into the flags; the first turn sets the winding reference
  function automatic poly_flags_t note_turn(input poly_flags_t f, input turn_sign_t t,
                                            input logic is_first);
    poly_flags_t r;
    r = f;
    if (t.neg) begin
      r.nonneg = 1'b0;
    end
    if (is_first) begin
      r.first_ccw = !t.neg;
    end else if (f.first_ccw ? t.neg : t.pos) begin
      r.mismatch = 1'b1;
    end
    return r;
  endfunction

  // Add a term and clamp to the area range; top bit flags a clip
  function automatic logic [AB:0] sat_add(input logic signed [AB-1:0] a,
                                          input logic signed [TERM-1:0] t);
    logic signed [SW-1:0] s;
    s = SW'(a) + SW'(t);
    if (s > SW'(pawc_pkg::AREA_MAX)) begin
      return {1'b1, pawc_pkg::AREA_MAX};
    end else if (s < SW'(pawc_pkg::AREA_MIN)) begin
      return {1'b1, pawc_pkg::AREA_MIN};
    end
    return {1'b0, s[AB-1:0]};
  endfunction

  logic                     en;
  pawc_pkg::step_cls_t      e_cls;
  logic signed [COORD_BITS-1:0] e_crd [pawc_pkg::CRD_COUNT];

  logic                     s1_valid;
  pawc_pkg::step_cls_t      s1_cls;
  logic signed [DW-1:0]     s1_d [NDIFF];
  logic signed [COORD_BITS-1:0] s1_pa [NPROD];
  logic signed [COORD_BITS-1:0] s1_pb [NPROD];

  logic                     s2_valid;
  pawc_pkg::step_cls_t      s2_cls;
  logic signed [QW-1:0]     s2_q [NDIFF/2];
  logic signed [PW-1:0]     s2_p [NPROD];

  logic                     s3_valid;
  pawc_pkg::step_cls_t      s3_cls;
  turn_sign_t               s3_sign [3];
  logic signed [TERM-1:0]   s3_term [2];
  logic signed [TW-1:0]     turn_val [3];

  logic                     s4_valid;
  pawc_pkg::step_cls_t      s4_cls;
  turn_sign_t               s4_sign [2];
  logic signed [TERM-1:0]   s4_term;
  logic signed [AB-1:0]     s4_acc;
  poly_flags_t              s4_flags;

  logic signed [AB-1:0]     acc;
  poly_flags_t              flags;
  logic signed [AB-1:0]     acc_next;
  poly_flags_t              flags_next;
  logic [AB:0]              add4;

  logic [AB:0]              add5;
  poly_flags_t              flags5;

  // Hold the whole pipeline while a result waits
  assign en        = !result.valid || result.ready;
  assign pop_ready = en;

  // Unpack the queue word
  assign e_cls = pawc_pkg::step_cls_t'(pop_data[ENTRY_BITS-1 -: CLS_BITS]);
  always_comb begin
    for (int j = 0; j < pawc_pkg::CRD_COUNT; j++) begin
      e_crd[j] = pop_data[(pawc_pkg::CRD_COUNT-1-j)*COORD_BITS +: COORD_BITS];
    end
  end

  // Stage 1: coordinate differences, select shoelace operands
  always_ff @(posedge clk) begin
    if (en) begin
      s1_cls <= e_cls;
      for (int j = 0; j < NDIFF; j++) begin
        s1_d[j] <= DW'(e_crd[DIFF_A[j]]) - DW'(e_crd[DIFF_B[j]]);
      end
      for (int j = 0; j < NPROD; j++) begin
        s1_pa[j] <= e_crd[PROD_A[j]];
        s1_pb[j] <= e_crd[PROD_B[j]];
      end
    end
  end

  // Stage 2: products
  always_ff @(posedge clk) begin
    if (en) begin
      s2_cls <= s1_cls;
      for (int j = 0; j < NDIFF/2; j++) begin
        s2_q[j] <= QW'(s1_d[2*j]) * QW'(s1_d[2*j+1]);
      end
      for (int j = 0; j < NPROD; j++) begin
        s2_p[j] <= PW'(s1_pa[j]) * PW'(s1_pb[j]);
      end
    end
  end

  // Stage 3: cross terms and turn signs
  always_comb begin
    for (int t = 0; t < 3; t++) begin
      turn_val[t] = TW'(s2_q[2*t]) - TW'(s2_q[2*t+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_cls <= s2_cls;
      for (int t = 0; t < 3; t++) begin
        s3_sign[t].neg <= turn_val[t][TW-1];
        s3_sign[t].pos <= !turn_val[t][TW-1] && (turn_val[t] != '0);
      end
      for (int j = 0; j < 2; j++) begin
        s3_term[j] <= TERM'(s2_p[2*j]) - TERM'(s2_p[2*j+1]);
      end
    end
  end

  // Stage 4: accumulate the running sum and the running turn
  always_comb begin
    flags_next = flags;
    acc_next   = acc;
    add4       = sat_add(acc, s3_term[0]);
    if (s3_cls.turn) begin
      flags_next = note_turn(flags, s3_sign[0], s3_cls.first_turn);
    end
    if (s3_cls.acc) begin
      acc_next           = add4[AB-1:0];
      flags_next.clipped = flags_next.clipped | add4[AB];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      flags <= FLAGS_RESET;
    end else if (en && s3_valid) begin
      if (s3_cls.last) begin
        acc   <= '0;
        flags <= FLAGS_RESET;
      end else begin
        acc   <= acc_next;
        flags <= flags_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_cls     <= s3_cls;
      s4_sign[0] <= s3_sign[1];
      s4_sign[1] <= s3_sign[2];
      s4_term    <= s3_term[1];
      s4_acc     <= acc_next;
      s4_flags   <= flags_next;
    end
  end

  // Stage 5: close the loop and form the result
  always_comb begin
    add5   = sat_add(s4_acc, s4_term);
    flags5 = note_turn(note_turn(s4_flags, s4_sign[0], 1'b0), s4_sign[1], 1'b0);
    flags5.clipped = flags5.clipped | add5[AB];
  end

  always_ff @(posedge clk) begin
    if (en && s4_valid && s4_cls.last) begin
      if (s4_cls.closing) begin
        result.doubled_area     <= add5[AB-1:0];
        result.counterclockwise <= flags5.nonneg;
        result.convex           <= s4_cls.first_turn || !flags5.mismatch;
        result.area_saturated   <= flags5.clipped;
      end else begin
        result.doubled_area     <= '0;
        result.counterclockwise <= 1'b1;
        result.convex           <= 1'b1;
        result.area_saturated   <= 1'b0;
      end
    end
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else if (en) begin
      s1_valid     <= pop_valid;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      s4_valid     <= s3_valid;
      result.valid <= s4_valid && s4_cls.last;
    end
  end

  // A polygon end leaving stage 4 must show up as a result next cycle
  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    en && s4_valid && s4_cls.last |=> result.valid)
    else $error("polygon end did not produce a result");

  // A polygon end must leave the running state cleared for the next polygon
  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    en && s3_valid && s3_cls.last |=> (acc == '0) && (flags == FLAGS_RESET))
    else $error("running state not cleared after polygon end");

  // Counterclockwise means no negative turn, so the winding cannot mismatch
  a_ccw_convex: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (!result.counterclockwise || result.convex))
    else $error("counterclockwise result reported as non-convex");

endmodule

/* dv/pawc_area_check.sv */
// Predictor and scoreboard for the polygon area, winding and convexity block.
// Watches both channels, predicts each polygon result and compares it field by field.
// Depends on pawc_pkg, pawc_vertex_if and pawc_result_if.
module pawc_area_check #(
  parameter int COORD_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  pawc_vertex_if  vertex,
  pawc_result_if  result,
  output int      mismatch_count,
  output int      pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AREA_BITS = pawc_pkg::AREA_BITS;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [AREA_BITS-1:0] doubled_area;
    logic                        counterclockwise;
    logic                        convex;
    logic                        area_saturated;
  } polygon_result_t;

  // Running state of the polygon in progress
  logic signed [COORD_BITS-1:0]     v0_x, v0_y, v1_x, v1_y;
  logic signed [COORD_BITS-1:0]     back2_x, back2_y, back1_x, back1_y;
  logic [pawc_pkg::COUNT_BITS-1:0]  seen;
  logic signed [AREA_BITS-1:0]      shoelace_sum;
  logic                             no_right_turn;
  logic                             ref_left;
  logic                             turn_conflict;
  logic                             clipped;

  polygon_result_t polygon_results_q[$];

  task automatic clear_polygon();
    v0_x = '0; v0_y = '0; v1_x = '0; v1_y = '0;
    back2_x = '0; back2_y = '0; back1_x = '0; back1_y = '0;
    seen = '0;
    shoelace_sum = '0;
    no_right_turn = 1'b1;
    ref_left = 1'b1;
    turn_conflict = 1'b0;
    clipped = 1'b0;
  endtask

  // Cross product of (b - a) and (c - a)
  function automatic longint turn_cross(longint ax, longint ay, longint bx, longint by,
                                        longint cx, longint cy);
    return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
  endfunction

  // Add one shoelace term, clamping to the accumulator range
  task automatic add_shoelace(input longint term);
    longint s;
    s = longint'(shoelace_sum) + term;
    if (s > longint'(pawc_pkg::AREA_MAX)) begin
      s = longint'(pawc_pkg::AREA_MAX);
      clipped = 1'b1;
    end else if (s < longint'(pawc_pkg::AREA_MIN)) begin
      s = longint'(pawc_pkg::AREA_MIN);
      clipped = 1'b1;
    end
    shoelace_sum = s[AREA_BITS-1:0];
  endtask

  // Fold one turn into the winding flags; the first turn sets the reference sense
  task automatic grade_turn(input longint t, input bit sets_reference);
    if (t < 0) no_right_turn = 1'b0;
    if (sets_reference) begin
      ref_left = (t >= 0);
    end else if (ref_left ? (t < 0) : (t > 0)) begin
      turn_conflict = 1'b1;
    end
  endtask

  // Advance the polygon by one vertex word; queue a result on the last one
  task automatic take_vertex(input logic signed [COORD_BITS-1:0] vx,
                             input logic signed [COORD_BITS-1:0] vy,
                             input logic lastv);
    longint                          cx, cy;
    logic [pawc_pkg::COUNT_BITS-1:0] k;
    polygon_result_t                 r;
    cx = vx;
    cy = vy;
    k = seen;
    if (k == '0) begin
      v0_x = vx;
      v0_y = vy;
    end else begin
      if (k == pawc_pkg::COUNT_SECOND) begin
        v1_x = vx;
        v1_y = vy;
      end
      add_shoelace(longint'(back1_x) * cy - longint'(back1_y) * cx);
      if (k >= pawc_pkg::COUNT_TURN)
        grade_turn(turn_cross(back2_x, back2_y, back1_x, back1_y, cx, cy),
                   k == pawc_pkg::COUNT_TURN);
    end

    if (!lastv) begin
      back2_x = back1_x;
      back2_y = back1_y;
      back1_x = vx;
      back1_y = vy;
      if (seen < pawc_pkg::COUNT_MAX) seen = seen + 1'b1;
    end else begin
      r.doubled_area = '0;
      r.counterclockwise = 1'b1;
      r.convex = 1'b1;
      r.area_saturated = 1'b0;
      // Close the loop: last edge back to v0 and the two wraparound turns
      if (k >= pawc_pkg::COUNT_TURN) begin
        add_shoelace(cx * longint'(v0_y) - cy * longint'(v0_x));
        grade_turn(turn_cross(back1_x, back1_y, cx, cy, v0_x, v0_y), 1'b0);
        grade_turn(turn_cross(cx, cy, v0_x, v0_y, v1_x, v1_y), 1'b0);
        r.doubled_area = shoelace_sum;
        r.counterclockwise = no_right_turn;
        r.convex = (k == pawc_pkg::COUNT_TURN) ? 1'b1 : !turn_conflict;
        r.area_saturated = clipped;
      end
      polygon_results_q.push_back(r);
      clear_polygon();
    end
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    polygon_result_t want, got;
    if (rst) begin
      clear_polygon();
      polygon_results_q.delete();
    end else begin
      if (vertex.valid && vertex.ready)
        take_vertex(vertex.vertex_x, vertex.vertex_y, vertex.last_vertex);
      if (result.valid && result.ready) begin
        got.doubled_area = result.doubled_area;
        got.counterclockwise = result.counterclockwise;
        got.convex = result.convex;
        got.area_saturated = result.area_saturated;
        if (polygon_results_q.size() == 0) begin
          if (mismatch_count < MAX_REPORTS)
            $display("%0t: result word with none expected: area=%0d ccw=%b convex=%b sat=%b",
                     $realtime, got.doubled_area, got.counterclockwise, got.convex,
                     got.area_saturated);
          mismatch_count++;
        end else begin
          want = polygon_results_q.pop_front();
          if (got.doubled_area !== want.doubled_area ||
              got.counterclockwise !== want.counterclockwise ||
              got.convex !== want.convex ||
              got.area_saturated !== want.area_saturated) begin
            if (mismatch_count < MAX_REPORTS) begin
              $display("%0t: expected area=%0d ccw=%b convex=%b sat=%b", $realtime,
                       want.doubled_area, want.counterclockwise, want.convex,
                       want.area_saturated);
              $display("%0t:   actual area=%0d ccw=%b convex=%b sat=%b", $realtime,
                       got.doubled_area, got.counterclockwise, got.convex,
                       got.area_saturated);
            end
            mismatch_count++;
          end
        end
      end
    end
    pending_results = polygon_results_q.size();
  end

endmodule

/* dv/polygon_area_winding_convexity_tb.sv */
// Top of the testbench: clock, reset, vertex stimulus, result back-pressure and verdict.
// Depends on pawc_pkg, the channel interfaces, the block itself and pawc_area_check.
module polygon_area_winding_convexity_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS      = 16;
  localparam int RANDOM_VERTICES = 850;
  localparam int CYCLE_LIMIT     = 60000;
  localparam int LONG_HOLD       = 120;
  localparam int DRAIN_CYCLES    = 16;

  typedef enum int {OUTLINE, OUTLINE_SHUFFLED, SCATTER_FULL, SCATTER_NEAR,
                    SCATTER_RAIL} polygon_kind_t;

  logic clk;
  logic rst = 1'b1;
  int   cycles;
  int   mismatch_count;
  int   pending_results;
  int   results_taken;
  bit   gapless;

  pawc_vertex_if #(.COORD_BITS(COORD_BITS)) vertex_ch ();
  pawc_result_if                            result_ch ();

  polygon_area_winding_convexity #(.COORD_BITS(COORD_BITS)) DUT (
    .clk    (clk),
    .rst    (rst),
    .vertex (vertex_ch),
    .result (result_ch)
  );

  pawc_area_check #(.COORD_BITS(COORD_BITS)) area_check (
    .clk             (clk),
    .rst             (rst),
    .vertex          (vertex_ch),
    .result          (result_ch),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic signed [COORD_BITS-1:0] pick_coord(polygon_kind_t kind);
    int rail[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    case (kind)
      SCATTER_NEAR: return COORD_BITS'(int'($urandom_range(0, 16)) - 8);
      SCATTER_RAIL: return COORD_BITS'(rail[$urandom_range(0, 6)]);
      default:      return COORD_BITS'($urandom());
    endcase
  endfunction

  // Offer one vertex word after a random gap, or none in gapless mode, and hold it until taken
  task automatic send_vertex(input logic signed [COORD_BITS-1:0] x,
                             input logic signed [COORD_BITS-1:0] y,
                             input logic lastv);
    int gap;
    gap = gapless ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      vertex_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    vertex_ch.valid <= 1'b1;
    vertex_ch.vertex_x <= x;
    vertex_ch.vertex_y <= y;
    vertex_ch.last_vertex <= lastv;
    @(posedge clk);
    while (!vertex_ch.ready) @(posedge clk);
  endtask

  // Result side: random stalls, unstalled stretches and two long hold-offs
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (results_taken == 15 || results_taken == 80) stall = LONG_HOLD;
      else if (results_taken % 32 < 8) stall = 0;
      else stall = $urandom_range(0, 5);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      results_taken++;
      @(negedge clk);
    end
  end

  // Vertex side: directed polygons, then random polygons
  initial begin
    int            script[25][3] = '{
      '{32767, -32768, 1},
      '{-32768, -32768, 0}, '{32767, 32767, 1},
      '{0, 0, 0}, '{10, 0, 0}, '{0, 10, 1},
      '{0, 0, 0}, '{0, 10, 0}, '{10, 0, 1},
      '{0, 0, 0}, '{10, 0, 0}, '{2, 2, 0}, '{0, 10, 1},
      '{0, 0, 0}, '{0, 10, 0}, '{2, 2, 0}, '{10, 0, 1},
      '{0, 0, 0}, '{5, 5, 0}, '{10, 10, 0}, '{20, 20, 1},
      '{32767, -32768, 0}, '{32767, 32767, 0}, '{-32768, 32767, 0}, '{-32768, -32768, 1}
    };
    int            sent, n, r, x0, y0, w, h, t, px, py, tmp;
    int            params[$];
    polygon_kind_t kind;

    vertex_ch.valid = 1'b0;
    vertex_ch.vertex_x = '0;
    vertex_ch.vertex_y = '0;
    vertex_ch.last_vertex = 1'b0;
    gapless = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: lone vertex, pair, triangles both ways, concave, collinear, rail square
    foreach (script[i]) send_vertex(COORD_BITS'(script[i][0]), COORD_BITS'(script[i][1]),
                                    script[i][2] != 0);

    // Random polygons, mostly rectangle outlines, most of them walked in order
    sent = 0;
    while (sent < RANDOM_VERTICES) begin
      r = $urandom_range(0, 9);
      if (r == 0) n = $urandom_range(1, 2);
      else if (r < 8) n = $urandom_range(3, 8);
      else n = $urandom_range(9, 14);
      gapless = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (r < 5) kind = OUTLINE;
      else if (r == 5) kind = OUTLINE_SHUFFLED;
      else if (r < 8) kind = SCATTER_FULL;
      else if (r == 8) kind = SCATTER_NEAR;
      else kind = SCATTER_RAIL;

      if (kind == OUTLINE || kind == OUTLINE_SHUFFLED) begin
        x0 = int'($urandom_range(0, 65534)) - 32768;
        y0 = int'($urandom_range(0, 65534)) - 32768;
        w = $urandom_range(1, 32767 - x0);
        h = $urandom_range(1, 32767 - y0);
        params.delete();
        repeat (n) params.push_back($urandom_range(0, 2 * (w + h) - 1));
        params.sort();
        if ($urandom_range(0, 1)) params.reverse();
        // break the ordering so the outline folds over itself
        if (kind == OUTLINE_SHUFFLED && n >= 4) begin
          tmp = params[0];
          params[0] = params[n / 2];
          params[n / 2] = tmp;
        end
        foreach (params[i]) begin
          t = params[i];
          if (t < w) begin
            px = x0 + t;
            py = y0;
          end else if (t < w + h) begin
            px = x0 + w;
            py = y0 + t - w;
          end else if (t < 2 * w + h) begin
            px = x0 + w - (t - w - h);
            py = y0 + h;
          end else begin
            px = x0;
            py = y0 + h - (t - 2 * w - h);
          end
          send_vertex(COORD_BITS'(px), COORD_BITS'(py), i == n - 1);
        end
      end else begin
        for (int i = 0; i < n; i++)
          send_vertex(pick_coord(kind), pick_coord(kind), i == n - 1);
      end
      sent += n;
    end
    gapless = 1'b0;

    @(negedge clk);
    vertex_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
